// ===== rtl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// dq_pkg : shared types and codes for the double-ended queue
// Request kinds, status codes and the operation decode passed from the
// ring pointer logic to the storage side.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

    // request kinds, as carried on s_tuser
    typedef enum logic [1:0] {
        KIND_PUSH_FRONT = 2'd0,
        KIND_PUSH_REAR  = 2'd1,
        KIND_POP_FRONT  = 2'd2,
        KIND_POP_REAR   = 2'd3
    } kind_t;

    // result status, as carried on m_tuser
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int unsigned VALUE_W = 32;

    // decoded operation for one request
    typedef struct packed {
        logic       wr_en;   // push accepted: write the slot
        logic       rd_en;   // pop accepted: read the slot
        logic [1:0] status;
    } dq_op_t;

endpackage

`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue : bounded deque of signed 32-bit values
// Ring of DEPTH slots in one synchronous memory, front index and count.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser selects push front, push rear,
//   pop front or pop rear, s_tdata carries the value to push. Each request
//   gives exactly one result on the m_ channel: m_tdata holds the popped
//   value (zero unless a pop succeeded) and the occupancy afterwards,
//   m_tuser holds the status (ok, pop on empty, push on full dropped).
//   A dropped push or empty pop leaves the queue unchanged.
//   The slot is written or read at the accepting edge; the result then passes
//   through the pending stage into the output register, which raises m_tvalid.
//   Throughput: one request per cycle while m_tready is high, as pointers
//   update at the accepting edge.
//   A request waits in one pending stage behind the output register; when
//   the receiver stalls, both fill and s_tready then drops.
//   Reset empties the queue (front index and count cleared). Slot contents
//   are not cleared; only written slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // request channel
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // [31:0] push_value
    input  wire logic [1:0]           s_tuser,   // [1:0] kind
    // result channel
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [((VALUE_W+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
                                      // [31:0] pop_value, then occupancy
    output logic [1:0]                m_tuser    // [1:0] status
);

    localparam int unsigned IW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH+1);
    localparam int unsigned TDW = ((VALUE_W + CW + 7) / 8) * 8;

    // ring state
    logic [IW-1:0]      head_reg;
    logic [CW-1:0]      count_reg;
    logic [VALUE_W-1:0] mem [DEPTH];
    logic [VALUE_W-1:0] rdata_reg;

    // pending stage: request done, read data on its way
    logic               pend_reg;
    logic               pend_rd_reg;
    logic [1:0]         pend_status_reg;
    logic [CW-1:0]      pend_occ_reg;

    // output register
    logic               out_valid_reg;
    logic [TDW-1:0]     out_data_reg;
    logic [1:0]         out_status_reg;

    dq_op_t             op;
    logic [IW-1:0]      addr;
    logic [IW-1:0]      head_next;
    logic [CW-1:0]      count_next;
    logic               s_fire;
    logic               out_free;
    logic               pend_move;
    logic [VALUE_W-1:0] pop_value;

    dq_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .kind       (s_tuser),
        .head       (head_reg),
        .count      (count_reg),
        .op         (op),
        .addr       (addr),
        .head_next  (head_next),
        .count_next (count_next)
    );

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign pend_move = pend_reg && out_free;
    assign s_tready  = !pend_reg || out_free;
    assign s_fire    = s_tvalid && s_tready;

    // slot memory: single port, registered read
    always_ff @(posedge aclk) begin
        if (s_fire && op.wr_en) begin
            mem[addr] <= s_tdata;
        end
        if (s_fire && op.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (s_fire) begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // pending stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (s_fire) begin
            pend_reg <= 1'b1;
        end else if (pend_move) begin
            pend_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pend_rd_reg     <= op.rd_en;
            pend_status_reg <= op.status;
            pend_occ_reg    <= count_next;
        end
    end

    // result assembly
    assign pop_value = pend_rd_reg ? rdata_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pend_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_move) begin
            out_data_reg   <= TDW'({pend_occ_reg, pop_value});
            out_status_reg <= pend_status_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_pend_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && pend_reg |-> out_free)
        else $error("request accepted over a stalled pending stage");

    a_fire_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> pend_reg)
        else $error("accepted request not held pending");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_status_reg != ST_OK) |->
            (out_data_reg[VALUE_W-1:0] == '0))
        else $error("failed request returned a value");

endmodule

`default_nettype wire

// ===== rtl/dq_ring.sv =====
// ----------------------------------------------------------------------------
// dq_ring : ring pointer arithmetic for the double-ended queue
// Decodes one request against the front index and entry count, giving the
// slot address, the memory access and the updated pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ring
    import dq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic [1:0]                 kind,
    input  wire logic [$clog2(DEPTH)-1:0]   head,
    input  wire logic [$clog2(DEPTH+1)-1:0] count,
    output dq_op_t                          op,
    output logic [$clog2(DEPTH)-1:0]        addr,
    output logic [$clog2(DEPTH)-1:0]        head_next,
    output logic [$clog2(DEPTH+1)-1:0]      count_next
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [IW:0]   DEPTH_X  = (IW+1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    logic          full;
    logic          empty;
    logic [IW-1:0] head_dec;
    logic [IW-1:0] head_inc;
    logic [IW:0]   rear_sum;
    logic [IW:0]   rear_raw;
    logic [IW-1:0] rear_pos;

    assign full  = (count == DEPTH_C);
    assign empty = (count == '0);

    // front index stepped either way, with wrap
    assign head_dec = (head == '0) ? LAST_IDX : head - IW'(1);
    assign head_inc = (head == LAST_IDX) ? '0 : head + IW'(1);

    // rear slot: head + count for a push, one less for a pop
    always_comb begin
        rear_sum = {1'b0, head} + (IW+1)'(count);
        if (kind == KIND_POP_REAR) begin
            rear_raw = rear_sum - (IW+1)'(1);
        end else begin
            rear_raw = rear_sum;
        end
        if (rear_raw >= DEPTH_X) begin
            rear_pos = IW'(rear_raw - DEPTH_X);
        end else begin
            rear_pos = rear_raw[IW-1:0];
        end
    end

    // per-kind decode
    always_comb begin
        op         = '0;
        op.status  = ST_OK;
        addr       = rear_pos;
        head_next  = head;
        count_next = count;
        case (kind)
            KIND_PUSH_FRONT: begin
                addr = head_dec;
                if (full) begin
                    op.status = ST_FULL;
                end else begin
                    op.wr_en   = 1'b1;
                    head_next  = head_dec;
                    count_next = count + CW'(1);
                end
            end
            KIND_PUSH_REAR: begin
                if (full) begin
                    op.status = ST_FULL;
                end else begin
                    op.wr_en   = 1'b1;
                    count_next = count + CW'(1);
                end
            end
            KIND_POP_FRONT: begin
                addr = head;
                if (empty) begin
                    op.status = ST_EMPTY;
                end else begin
                    op.rd_en   = 1'b1;
                    head_next  = head_inc;
                    count_next = count - CW'(1);
                end
            end
            default: begin
                if (empty) begin
                    op.status = ST_EMPTY;
                end else begin
                    op.rd_en   = 1'b1;
                    count_next = count - CW'(1);
                end
            end
        endcase
    end

endmodule

`default_nettype wire
